// ===== sv/lkv_pkg.sv =====
package lkv_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } lkv_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic load_out;
  } lkv_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lkv_status_t;

endpackage

// ===== sv/lkv_ctrl.sv =====
module lkv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lkv_pkg::lkv_status_t status,
  output lkv_pkg::lkv_cmd_t   cmd
);

  lkv_pkg::lkv_state_t state, state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lkv_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      lkv_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = lkv_pkg::ST_SCAN;
        end
      end
      lkv_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = lkv_pkg::ST_UPDATE;
        end
      end
      lkv_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = lkv_pkg::ST_RESULT;
      end
      lkv_pkg::ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lkv_datapath.sv =====
module lkv_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]           cfg_wdata,
  input  logic                                opcode,
  input  logic signed [lkv_pkg::DATA_W-1:0]   lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0]   write_value,
  output logic                                found,
  output logic signed [lkv_pkg::DATA_W-1:0]   read_value,
  input  lkv_pkg::lkv_cmd_t                   cmd,
  output lkv_pkg::lkv_status_t                status
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);
  localparam logic [CMP_W-1:0] ENTRIES_CMP = CMP_W'(ENTRIES);

  // key and value stores
  logic [lkv_pkg::DATA_W-1:0] key_mem [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] val_mem [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] key_q;
  logic [lkv_pkg::DATA_W-1:0] val_q;

  // per-entry control state
  logic [ENTRIES-1:0] valid;
  logic [AGE_W-1:0]   age [ENTRIES];
  logic [CNT_W-1:0]   live_count;
  logic [lkv_pkg::CAP_W-1:0] capacity;

  // request and scan state
  logic                       req_op;
  logic [lkv_pkg::DATA_W-1:0] req_key;
  logic [lkv_pkg::DATA_W-1:0] req_val;
  logic [CNT_W-1:0]           scan_idx;
  logic                       rd_pend;
  logic [IDX_W-1:0]           rd_idx;
  logic                       hit;
  logic [IDX_W-1:0]           hit_idx;
  logic [AGE_W-1:0]           hit_age;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;
  logic [IDX_W-1:0]           victim_idx;

  logic [ENTRIES-1:0] victim_vec;
  logic [AGE_W-1:0]   oldest_age;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic               room;
  logic               do_fill;
  logic               do_evict;
  logic               do_touch;
  logic [IDX_W-1:0]   slot;
  logic [AGE_W-1:0]   touch_age;

  assign oldest_age = AGE_W'(live_count - CNT_W'(1));

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      victim_vec[j] = valid[j] && (age[j] == oldest_age);
    end
  end

  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > ENTRIES_CMP) begin
      cap_eff = ENTRIES_CMP;
    end
  end
  assign room = CMP_W'(live_count) < cap_eff;

  assign status.scan_done = (scan_idx == ENTRIES_CNT) && !rd_pend;

  // decision taken in the update cycle
  assign do_fill  = (req_op == lkv_pkg::OP_PUT) && !hit && room;
  assign do_evict = (req_op == lkv_pkg::OP_PUT) && !hit && !room;
  assign do_touch = hit || do_evict;
  assign slot     = hit ? hit_idx : (do_fill ? free_idx : victim_idx);
  assign touch_age = hit ? hit_age : oldest_age;

  always_ff @(posedge clk) begin
    if (cmd.scan && (scan_idx != ENTRIES_CNT)) begin
      key_q <= key_mem[scan_idx[IDX_W-1:0]];
    end
    if (cmd.update) begin
      if (req_op == lkv_pkg::OP_GET) begin
        val_q <= val_mem[hit_idx];
      end else begin
        val_mem[slot] <= req_val;
        if (!hit) begin
          key_mem[slot] <= req_key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      live_count <= '0;
      capacity   <= lkv_pkg::CAP_RESET;
      rd_pend    <= 1'b0;
      scan_idx   <= ENTRIES_CNT;
      for (int j = 0; j < ENTRIES; j++) begin
        age[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      rd_pend <= 1'b0;
      if (cmd.start) begin
        scan_idx <= '0;
      end else if (cmd.scan && (scan_idx != ENTRIES_CNT)) begin
        rd_pend  <= 1'b1;
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (cmd.update && (do_fill || do_touch)) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (IDX_W'(j) == slot) begin
            age[j] <= '0;
          end else if (valid[j] && (do_fill || (age[j] < touch_age))) begin
            age[j] <= age[j] + AGE_W'(1);
          end
        end
        if (do_fill) begin
          valid[free_idx] <= 1'b1;
          live_count      <= live_count + CNT_W'(1);
        end
      end
    end
  end

  // request capture and compare stage, one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op     <= opcode;
      req_key    <= lookup_key;
      req_val    <= write_value;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_pend) begin
      if (valid[rd_idx] && (key_q == req_key)) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx;
        hit_age <= age[rd_idx];
      end
      if (!valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (victim_vec[rd_idx]) begin
        victim_idx <= rd_idx;
      end
    end
    if (cmd.scan) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.load_out) begin
      found <= hit;
      if (req_op == lkv_pkg::OP_PUT) begin
        read_value <= lkv_pkg::PUT_VALUE;
      end else if (hit) begin
        read_value <= val_q;
      end else begin
        read_value <= lkv_pkg::MISS_VALUE;
      end
    end
  end

endmodule

// ===== sv/lru_key_value_cache_core.sv =====
// lru key/value cache, fully associative, least recently used replacement
//
// input channel: in_valid/in_ready with opcode (get or put), lookup_key and
// write_value. output channel: out_valid/out_ready with found and read_value,
// one result per request, in request order.
// configuration: cfg_we/cfg_wdata write the capacity register at once; only
// write it while no request is in flight.
//
// a request walks the key store one entry a cycle through its single read
// port, then makes its update and loads its result into the output register;
// a new request is taken only after the last result has been loaded.
// the read port of the key store sets the pace of the walk.
//
// reset clears all valid marks, the ages, the live count and out_valid, and
// sets capacity to 16; no clearing pass is needed.
// if the receiver stalls, the result waits in the output register; the next
// request is still accepted and worked on, and only its delivery waits.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic signed [lkv_pkg::DATA_W-1:0] lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0] write_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic signed [lkv_pkg::DATA_W-1:0] read_value
);

  lkv_pkg::lkv_cmd_t    cmd;
  lkv_pkg::lkv_status_t status;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .opcode      (opcode),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .found       (found),
    .read_value  (read_value),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ===== sv/lkv_checker.sv =====
module lkv_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              found,
  input logic signed [lkv_pkg::DATA_W-1:0] read_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(read_value))
    else $error("stalled result changed");

  // nothing is shown straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time: busy after taking one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a miss only ever reports the miss or put value
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |->
      (read_value == lkv_pkg::MISS_VALUE) || (read_value == lkv_pkg::PUT_VALUE))
    else $error("bad value on miss");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .found      (found),
  .read_value (read_value)
);
